### hw/rtl/rfhs_pkg.sv
// rfhs_pkg: types, codes and constants of the random fill health sequencer
// used by the channel interfaces and every rtl module of the block

package rfhs_pkg;

  localparam int unsigned CfgW      = 20;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned LenW      = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned TickW     = 8;
  localparam int unsigned SpinW     = 20;
  localparam int unsigned CountW    = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  localparam logic [LenW-1:0]  MaxBytes    = 16'd4096;
  localparam logic [TickW-1:0] DeadlineRst = 8'd3;
  localparam logic [SpinW-1:0] SpinRst     = 20'd1000000;
  localparam logic [SpinW-1:0] SpinMax     = 20'hFFFFF;
  localparam logic [TickW-1:0] TickMax     = 8'hFF;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_CHUNK   = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_RESTART = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_READY = 3'd2,
    ST_BUS_ERR   = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RNG_READY = 2'd0,
    CFG_DEADLINE  = 2'd1,
    CFG_SPIN      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [LenW-1:0]  req_len;
    logic             buffer_present;
    logic             clock_ok;
    logic             clock_error;
    logic             seed_error;
    logic             data_ready;
    logic [WordW-1:0] rand_word;
  } req_t;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [WordW-1:0]  chunk_word;
    logic [CountW-1:0] byte_count;
    logic [2:0]        status;
    logic              wipe;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### hw/rtl/rfhs_req_if.sv
// rfhs_req_if: request channel, valid/ready with the request fields
// depends on rfhs_pkg

interface rfhs_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [rfhs_pkg::LenW-1:0] req_len;
  logic                      buffer_present;
  logic                      clock_ok;
  logic                      clock_error;
  logic                      seed_error;
  logic                      data_ready;
  logic [rfhs_pkg::WordW-1:0] rand_word;

  modport source (
    output valid, req_type, req_len, buffer_present, clock_ok,
           clock_error, seed_error, data_ready, rand_word,
    input  ready
  );
  modport sink (
    input  valid, req_type, req_len, buffer_present, clock_ok,
           clock_error, seed_error, data_ready, rand_word,
    output ready
  );
endinterface

### hw/rtl/rfhs_res_if.sv
// rfhs_res_if: result channel, valid/ready with the result fields
// depends on rfhs_pkg

interface rfhs_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   out_kind;
  logic [rfhs_pkg::WordW-1:0]   chunk_word;
  logic [rfhs_pkg::CountW-1:0]  byte_count;
  logic [2:0]                   status;
  logic                         wipe;
  logic                         last;

  modport source (
    output valid, out_kind, chunk_word, byte_count, status, wipe, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, chunk_word, byte_count, status, wipe, last,
    output ready
  );
endinterface

### hw/rtl/rng_fill_health_sequencer.sv
// rng_fill_health_sequencer: top level, input register, sequencer core, result queue
// depends on rfhs_pkg, rfhs_req_if, rfhs_res_if, rfhs_core, rfhs_res_fifo
//
//   port     dir  kind         contents
//   req_i    in   valid/ready  start, poll observation or tick request
//   res_o    out  valid/ready  data chunk, request status or restart command
//   cfg_*_i  in   write only   rng_ready, deadline_ticks, spin_limit
//
// a request is registered, then handled by the core once the queue has room; the
// core pushes up to two results into a four-entry queue; one request per cycle is
// taken while the queue has room for two more results, and one result leaves per
// cycle while res_o.ready is high; a poll that ends a request with data gives two
// results; reset is asynchronous; the queue and request state clear at once

module rng_fill_health_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rfhs_req_if.sink                      req_i,
  rfhs_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [rfhs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfhs_pkg::CfgW-1:0]     cfg_wdata_i
);

  logic            vld_q, vld_d;
  rfhs_pkg::req_t  req_q;
  logic            space;
  logic            go;
  logic            accept;
  rfhs_pkg::push_t push;
  rfhs_pkg::res_t  head;

  assign go          = vld_q && space;
  assign req_i.ready = !vld_q || go;
  assign accept      = req_i.valid && req_i.ready;
  assign vld_d       = accept ? 1'b1 : (go ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type       <= req_i.req_type;
      req_q.req_len        <= req_i.req_len;
      req_q.buffer_present <= req_i.buffer_present;
      req_q.clock_ok       <= req_i.clock_ok;
      req_q.clock_error    <= req_i.clock_error;
      req_q.seed_error     <= req_i.seed_error;
      req_q.data_ready     <= req_i.data_ready;
      req_q.rand_word      <= req_i.rand_word;
    end
  end

  rfhs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .go_i        (go),
    .req_i       (req_q),
    .push_o      (push)
  );

  rfhs_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (head)
  );

  assign res_o.out_kind   = head.out_kind;
  assign res_o.chunk_word = head.chunk_word;
  assign res_o.byte_count = head.byte_count;
  assign res_o.status     = head.status;
  assign res_o.wipe       = head.wipe;
  assign res_o.last       = head.last;

endmodule

### hw/rtl/rfhs_core.sv
// rfhs_core: configuration registers, request state and result generation
// depends on rfhs_pkg

module rfhs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfhs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfhs_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          go_i,
  input  rfhs_pkg::req_t                req_i,
  output rfhs_pkg::push_t               push_o
);

  logic                          rng_ready_q;
  logic [rfhs_pkg::TickW-1:0]    deadline_q;
  logic [rfhs_pkg::SpinW-1:0]    spin_limit_q;

  logic                          busy_q, busy_d;
  logic [rfhs_pkg::LenW-1:0]     bytes_q, bytes_d;
  logic [rfhs_pkg::TickW-1:0]    elapsed_q, elapsed_d;
  logic [rfhs_pkg::SpinW-1:0]    spin_q, spin_d;
  logic                          restart_q, restart_d;
  logic [rfhs_pkg::WordW-1:0]    prev_q, prev_d;
  logic                          prev_vld_q, prev_vld_d;

  logic [rfhs_pkg::CountW-1:0]   chunk;
  logic [rfhs_pkg::LenW-1:0]     bytes_rem;
  logic [rfhs_pkg::SpinW-1:0]    spin_inc;

  function automatic rfhs_pkg::res_t mk_status(rfhs_pkg::status_e st, logic wipe);
    rfhs_pkg::res_t r;
    r            = '0;
    r.out_kind   = rfhs_pkg::KIND_STATUS;
    r.status     = st;
    r.wipe       = wipe;
    r.last       = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_ready_q  <= 1'b0;
      deadline_q   <= rfhs_pkg::DeadlineRst;
      spin_limit_q <= rfhs_pkg::SpinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfhs_pkg::CFG_RNG_READY: rng_ready_q  <= cfg_wdata_i[0];
        rfhs_pkg::CFG_DEADLINE:  deadline_q   <= cfg_wdata_i[rfhs_pkg::TickW-1:0];
        rfhs_pkg::CFG_SPIN:      spin_limit_q <= cfg_wdata_i[rfhs_pkg::SpinW-1:0];
        default: ;
      endcase
    end
  end

  assign chunk     = (bytes_q > rfhs_pkg::LenW'(4)) ? 3'd4 : bytes_q[rfhs_pkg::CountW-1:0];
  assign bytes_rem = bytes_q - {{(rfhs_pkg::LenW-rfhs_pkg::CountW){1'b0}}, chunk};
  assign spin_inc  = (spin_q == rfhs_pkg::SpinMax) ? spin_q : spin_q + 1'b1;

  always_comb begin
    busy_d     = busy_q;
    bytes_d    = bytes_q;
    elapsed_d  = elapsed_q;
    spin_d     = spin_q;
    restart_d  = restart_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    push_o     = '0;
    if (go_i) begin
      case (req_i.req_type)
        rfhs_pkg::REQ_START: begin
          if (!busy_q) begin
            push_o.num = 2'd1;
            if ((!req_i.buffer_present && req_i.req_len != '0) ||
                req_i.req_len > rfhs_pkg::MaxBytes) begin
              push_o.first = mk_status(rfhs_pkg::ST_INVALID, 1'b0);
            end else if (req_i.req_len == '0) begin
              push_o.first = mk_status(rfhs_pkg::ST_OK, 1'b0);
            end else if (!rng_ready_q) begin
              push_o.first = mk_status(rfhs_pkg::ST_NOT_READY, 1'b0);
            end else if (!req_i.clock_ok) begin
              push_o.first = mk_status(rfhs_pkg::ST_BUS_ERR, 1'b1);
            end else begin
              push_o.num = 2'd0;
              busy_d     = 1'b1;
              bytes_d    = req_i.req_len;
              elapsed_d  = '0;
              spin_d     = '0;
              restart_d  = 1'b0;
            end
          end
        end
        rfhs_pkg::REQ_TICK: begin
          if (busy_q && elapsed_q != rfhs_pkg::TickMax) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        rfhs_pkg::REQ_POLL: begin
          if (busy_q) begin
            if (req_i.clock_error ||
                (req_i.seed_error && restart_q) ||
                (!req_i.seed_error && req_i.data_ready && prev_vld_q &&
                 req_i.rand_word == prev_q)) begin
              busy_d       = 1'b0;
              push_o.num   = 2'd1;
              push_o.first = mk_status(rfhs_pkg::ST_BUS_ERR, 1'b1);
            end else if (req_i.seed_error) begin
              restart_d             = 1'b1;
              push_o.num            = 2'd1;
              push_o.first.out_kind = rfhs_pkg::KIND_RESTART;
            end else if (req_i.data_ready) begin
              prev_d                  = req_i.rand_word;
              prev_vld_d              = 1'b1;
              bytes_d                 = bytes_rem;
              push_o.num              = 2'd1;
              push_o.first.out_kind   = rfhs_pkg::KIND_CHUNK;
              push_o.first.chunk_word = req_i.rand_word;
              push_o.first.byte_count = chunk;
              if (bytes_rem == '0) begin
                busy_d        = 1'b0;
                push_o.num    = 2'd2;
                push_o.second = mk_status(rfhs_pkg::ST_OK, 1'b0);
              end
            end else begin
              spin_d = spin_inc;
              if (elapsed_q >= deadline_q || spin_inc >= spin_limit_q) begin
                busy_d       = 1'b0;
                push_o.num   = 2'd1;
                push_o.first = mk_status(rfhs_pkg::ST_TIMEOUT, 1'b1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      bytes_q    <= '0;
      elapsed_q  <= '0;
      spin_q     <= '0;
      restart_q  <= 1'b0;
      prev_vld_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      bytes_q    <= bytes_d;
      elapsed_q  <= elapsed_d;
      spin_q     <= spin_d;
      restart_q  <= restart_d;
      prev_vld_q <= prev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

### hw/rtl/rfhs_res_fifo.sv
// rfhs_res_fifo: small result queue, two writes and one read per cycle
// depends on rfhs_pkg

module rfhs_res_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rfhs_pkg::push_t             push_i,
  output logic                        space_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output rfhs_pkg::res_t              data_o
);

  rfhs_pkg::res_t                mem_q [rfhs_pkg::FifoDepth];
  logic [rfhs_pkg::PtrW-1:0]     wr_q, rd_q;
  logic [rfhs_pkg::FillW-1:0]    fill_q;
  logic                          pop;
  logic [rfhs_pkg::PtrW-1:0]     wr_next;

  assign valid_o = fill_q != '0;
  assign space_o = fill_q <= rfhs_pkg::FillW'(rfhs_pkg::FifoDepth - 2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_q];
  assign wr_next = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + rfhs_pkg::PtrW'(push_i.num);
      rd_q   <= rd_q + rfhs_pkg::PtrW'(pop);
      fill_q <= fill_q + rfhs_pkg::FillW'(push_i.num) - rfhs_pkg::FillW'(pop);
    end
  end

endmodule

### sim/testbench.sv
// testbench: checks the random fill health sequencer against a cycle-free
// prediction of its requests, chunks and status results
// depends on rfhs_pkg, rfhs_req_if, rfhs_res_if and rng_fill_health_sequencer

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfhs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int CycleLimit = 500000;
  localparam int PhaseItems = 40;

  typedef struct packed {
    logic              is_write;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]   wdata;
    req_t              req;
    logic              typed;
    res_t              res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  rfhs_req_if req_if ();
  rfhs_res_if res_if ();

  rng_fill_health_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5ns clk_i = ~clk_i;

  // register copies and request state
  logic             cfg_ready    = 1'b0;
  logic [TickW-1:0] cfg_deadline = DeadlineRst;
  logic [SpinW-1:0] cfg_spin     = SpinRst;
  logic             seq_busy     = 1'b0;
  logic [16:0]      seq_left     = '0;
  logic [TickW-1:0] seq_ticks    = '0;
  logic [SpinW-1:0] seq_spins    = '0;
  logic             seq_restart  = 1'b0;
  logic [WordW-1:0] seq_prev;
  logic             seq_prev_ok  = 1'b0;

  res_t results_owed[$];
  stim_row_t stim_rows[$];
  int fail_count = 0;
  int items_done = 0;
  int cycle_count = 0;
  bit req_steady = 1'b0;
  bit res_steady = 1'b0;

  function automatic res_t status_res(status_e st, logic wipe);
    return res_t'{KIND_STATUS, 32'd0, 3'd0, st, wipe, 1'b1};
  endfunction

  function automatic void end_request(status_e st, logic wipe, bit record);
    seq_busy = 1'b0;
    if (record) results_owed.push_back(status_res(st, wipe));
  endfunction

  function automatic bit fill_step(input req_t r, input bit record);
    logic [16:0] chunk;
    if (r.req_type == REQ_START) begin
      if (seq_busy) return 1'b0;
      if ((!r.buffer_present && r.req_len != '0) || r.req_len > MaxBytes)
        end_request(ST_INVALID, 1'b0, record);
      else if (r.req_len == '0) end_request(ST_OK, 1'b0, record);
      else if (!cfg_ready) end_request(ST_NOT_READY, 1'b0, record);
      else if (!r.clock_ok) end_request(ST_BUS_ERR, 1'b1, record);
      else begin
        seq_busy = 1'b1;
        seq_left = {1'b0, r.req_len};
        seq_ticks = '0;
        seq_spins = '0;
        seq_restart = 1'b0;
      end
      return 1'b1;
    end
    if (!seq_busy || r.req_type == REQ_UNUSED) return 1'b0;
    if (r.req_type == REQ_TICK) begin
      if (seq_ticks < TickMax) seq_ticks++;
    end else if (r.clock_error) begin
      end_request(ST_BUS_ERR, 1'b1, record);
    end else if (r.seed_error) begin
      if (seq_restart) end_request(ST_BUS_ERR, 1'b1, record);
      else begin
        seq_restart = 1'b1;
        if (record) results_owed.push_back(res_t'{KIND_RESTART, 32'd0, 3'd0, ST_OK, 1'b0, 1'b0});
      end
    end else if (r.data_ready) begin
      if (seq_prev_ok && r.rand_word == seq_prev) end_request(ST_BUS_ERR, 1'b1, record);
      else begin
        seq_prev = r.rand_word;
        seq_prev_ok = 1'b1;
        chunk = (seq_left > 17'd4) ? 17'd4 : seq_left;
        seq_left -= chunk;
        if (record) results_owed.push_back(res_t'{KIND_CHUNK, r.rand_word, chunk[2:0], ST_OK,
                                                  1'b0, 1'b0});
        if (seq_left == '0) end_request(ST_OK, 1'b0, record);
      end
    end else begin
      if (seq_spins < SpinMax) seq_spins++;
      if (seq_ticks >= cfg_deadline || seq_spins >= cfg_spin)
        end_request(ST_TIMEOUT, 1'b1, record);
    end
    return 1'b1;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, logic [LenW-1:0] len, logic has_buf,
                                  logic clk_ok, logic clk_err, logic seed_err, logic ready,
                                  logic [WordW-1:0] word);
    return req_t'{kind, len, has_buf, clk_ok, clk_err, seed_err, ready, word};
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.req_type = 2'($urandom_range(0, 3));
    r.req_len = 16'($urandom());
    {r.buffer_present, r.clock_ok, r.clock_error, r.seed_error, r.data_ready} = 5'($urandom());
    r.rand_word = $urandom();
    return r;
  endfunction

  function automatic stim_row_t req_row(req_t r, logic typed, res_t x);
    return stim_row_t'{1'b0, CFG_RNG_READY, 20'd0, r, typed, x};
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    return stim_row_t'{1'b1, idx, data, '0, 1'b0, '0};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_req(input req_t r, input bit typed, input res_t typed_res);
    int gap;
    gap = req_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= r.req_type;
    req_if.req_len        <= r.req_len;
    req_if.buffer_present <= r.buffer_present;
    req_if.clock_ok       <= r.clock_ok;
    req_if.clock_error    <= r.clock_error;
    req_if.seed_error     <= r.seed_error;
    req_if.data_ready     <= r.data_ready;
    req_if.rand_word      <= r.rand_word;
    do @(posedge clk_i); while (!req_if.ready);
    if (fill_step(r, !typed)) items_done++;
    if (typed) results_owed.push_back(typed_res);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (results_owed.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_RNG_READY: cfg_ready = data[0];
      CFG_DEADLINE:  cfg_deadline = data[TickW-1:0];
      CFG_SPIN:      cfg_spin = data[SpinW-1:0];
      default: ;
    endcase
  endtask

  // one start request with random content, then random polls while busy; a clock error ends it if still busy
  task automatic fill_sequence();
    req_t r;
    int pick;
    int polls;
    r = random_req();
    r.req_type = REQ_START;
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      if (pick < 70) r.req_len = 16'($urandom_range(1, 24));
      else if (pick < 86) r.req_len = 16'($urandom_range(25, 200));
      else r.req_len = MaxBytes + 16'($urandom_range(0, 1));
      r.buffer_present = ($urandom_range(0, 19) != 0);
      r.clock_ok = ($urandom_range(0, 14) != 0);
    end
    send_req(r, 1'b0, '0);
    polls = 0;
    while (seq_busy && polls < 60) begin
      r = random_req();
      r.req_type = REQ_POLL;
      pick = $urandom_range(0, 99);
      if (pick < 8) r.req_type = REQ_TICK;
      else if (pick < 11) r.req_type = REQ_START;
      else if (pick < 12) r.req_type = REQ_UNUSED;
      else if (pick < 14) r.clock_error = 1'b1;
      else if (pick < 19) begin
        r.clock_error = 1'b0;
        r.seed_error = 1'b1;
      end else begin
        r.clock_error = 1'b0;
        r.seed_error = 1'b0;
        r.data_ready = (pick >= 30);
        if (pick < 33 && seq_prev_ok) r.rand_word = seq_prev;
      end
      send_req(r, 1'b0, '0);
      polls++;
    end
    if (seq_busy) begin
      r = random_req();
      r.req_type = REQ_POLL;
      r.clock_error = 1'b1;
      send_req(r, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (results_owed.size() == 0) begin
        $error("result with nothing outstanding: kind %0d status %0d",
               res_if.out_kind, res_if.status);
        fail_count++;
      end else begin
        want = results_owed.pop_front();
        check_field("out_kind", 32'(want.out_kind), 32'(res_if.out_kind));
        check_field("chunk_word", want.chunk_word, res_if.chunk_word);
        check_field("byte_count", 32'(want.byte_count), 32'(res_if.byte_count));
        check_field("status", 32'(want.status), 32'(res_if.status));
        check_field("wipe", 32'(want.wipe), 32'(res_if.wipe));
        check_field("last", 32'(want.last), 32'(res_if.last));
      end
    end
  end

  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = res_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    logic             ready_v;
    logic [TickW-1:0] deadline_v;
    logic [SpinW-1:0] spin_v;
    int               phase_end;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_wdata_i           = '0;
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_START;
    req_if.req_len        = '0;
    req_if.buffer_present = 1'b0;
    req_if.clock_ok       = 1'b0;
    req_if.clock_error    = 1'b0;
    req_if.seed_error     = 1'b0;
    req_if.data_ready     = 1'b0;
    req_if.rand_word      = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    stim_rows = '{
      req_row(mk_req(REQ_START, 16'd8, 1, 1, 0, 0, 0, 0), 1'b1, status_res(ST_NOT_READY, 0)),
      req_row(mk_req(REQ_START, 16'd0, 0, 1, 0, 0, 0, 0), 1'b1, status_res(ST_OK, 0)),
      req_row(mk_req(REQ_START, MaxBytes + 16'd1, 1, 1, 0, 0, 0, 0), 1'b1,
              status_res(ST_INVALID, 0)),
      req_row(mk_req(REQ_START, 16'd5, 0, 1, 0, 0, 0, 0), 1'b1, status_res(ST_INVALID, 0)),
      req_row(mk_req(REQ_START, 16'hFFFF, 1, 0, 1, 1, 1, '1), 1'b1,
              status_res(ST_INVALID, 0)),
      req_row(mk_req(REQ_POLL, '1, 1, 1, 1, 1, 1, '1), 1'b0, '0),
      req_row(mk_req(REQ_TICK, '0, 0, 0, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_UNUSED, 16'd4, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      cfg_row(CFG_RNG_READY, 20'hFFFFF),
      cfg_row(CFG_UNUSED, 20'h00000),
      req_row(mk_req(REQ_START, 16'd4, 1, 0, 0, 0, 0, 0), 1'b1, status_res(ST_BUS_ERR, 1)),
      req_row(mk_req(REQ_START, 16'd6, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_START, 16'd2, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_TICK, '0, 0, 0, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 1, 1, 32'h1234_5678), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 1, 32'h0000_0000), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF), 1'b0, '0),
      req_row(mk_req(REQ_START, 16'd3, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF), 1'b1,
              status_res(ST_BUS_ERR, 1)),
      req_row(mk_req(REQ_START, MaxBytes, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 1, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 1, 0, 0), 1'b1, status_res(ST_BUS_ERR, 1)),
      req_row(mk_req(REQ_START, 16'd2, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 1, 1, 1, 32'hA5A5_5A5A), 1'b1,
              status_res(ST_BUS_ERR, 1)),
      cfg_row(CFG_DEADLINE, 20'hFFF00),
      req_row(mk_req(REQ_START, 16'd1, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 0, 0), 1'b1, status_res(ST_TIMEOUT, 1)),
      cfg_row(CFG_DEADLINE, 20'h000FF),
      cfg_row(CFG_SPIN, 20'd1),
      req_row(mk_req(REQ_START, 16'd1, 1, 1, 0, 0, 0, 0), 1'b0, '0),
      req_row(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 0, 0), 1'b1, status_res(ST_TIMEOUT, 1))
    };
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_write) begin
        settle();
        write_reg(stim_rows[i].idx, stim_rows[i].wdata);
      end else begin
        send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);
      end
    end

    for (int p = 0; p < 6; p++) begin
      ready_v = (p != 3);
      case (p)
        0: begin
          deadline_v = TickMax;
          spin_v = SpinMax;
        end
        1: begin
          deadline_v = 8'd1;
          spin_v = 20'd1;
        end
        2, 3: begin
          deadline_v = 8'($urandom_range(0, 12));
          spin_v = 20'($urandom_range(1, 16));
        end
        4: begin
          deadline_v = DeadlineRst;
          spin_v = SpinRst;
        end
        default: begin
          deadline_v = 8'($urandom_range(1, 255));
          spin_v = 20'($urandom_range(1, SpinMax));
        end
      endcase
      settle();
      write_reg(CFG_RNG_READY, {19'($urandom()), ready_v});
      write_reg(CFG_DEADLINE, {12'($urandom()), deadline_v});
      write_reg(CFG_SPIN, spin_v);
      req_steady = (p == 1 || p == 4);
      res_steady = (p == 2 || p == 4);
      phase_end = items_done + PhaseItems;
      if (p == 0) begin
        // tick counter saturates, then the next empty poll times out
        req_steady = 1'b1;
        send_req(mk_req(REQ_START, 16'd1, 1, 1, 0, 0, 0, 0), 1'b0, '0);
        repeat (260) send_req(mk_req(REQ_TICK, '0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        send_req(mk_req(REQ_POLL, '0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        req_steady = 1'b0;
      end
      while (items_done < phase_end) begin
        if ($urandom_range(0, 99) < 85) fill_sequence();
        else send_req(random_req(), 1'b0, '0);
      end
    end

    settle();
    repeat (12) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
